/* rtl/fse_pkg.sv */
// ----------------------------------------------------------------------------
// fse_pkg
// Shared types, codes and sector layout helpers for the sector erase job unit.
// ----------------------------------------------------------------------------
package fse_pkg;

  localparam int unsigned FseSmallSectorBytes  = 16384;
  localparam int unsigned FseMediumSectorBytes = 65536;
  localparam int unsigned FseLargeSectorBytes  = 131072;
  localparam int unsigned FseSectorCount       = 12;

  localparam int unsigned FseOffsetWidth = 21;
  localparam int unsigned FseSectorWidth = 4;
  localparam int unsigned FseLeftWidth   = 5;
  localparam int unsigned FseAddrWidth   = 32;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ERASE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_UNINIT = 2'd0,
    ST_IDLE   = 2'd1,
    ST_BUSY   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_UNINIT = 3'd1,
    ERR_BUSY   = 3'd2,
    ERR_ADDR   = 3'd3,
    ERR_LEN    = 3'd4
  } err_e;

  typedef struct packed {
    logic [1:0]                command;
    logic [FseOffsetWidth-1:0] address_offset;
    logic [FseOffsetWidth-1:0] length_bytes;
    logic                      flash_busy;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                error_code;
    logic [1:0]                status_now;
    logic                      job_result;
    logic                      erase_issue;
    logic [FseSectorWidth-1:0] erase_sector;
  } out_item_t;

  // Range check and sector lookup for one erase request
  typedef struct packed {
    logic                      addr_bad;
    logic                      len_bad;
    logic [FseSectorWidth-1:0] first;
    logic [FseLeftWidth-1:0]   count;
  } sector_map_t;

  // Byte offset at which sector idx starts; idx equal to the sector count
  // gives the flash size.
  function automatic logic [FseAddrWidth-1:0] sector_start(
    input int unsigned idx,
    input int unsigned small_bytes,
    input int unsigned medium_bytes,
    input int unsigned large_bytes
  );
    logic [FseAddrWidth-1:0] start;
    if (idx <= 4) begin
      start = FseAddrWidth'(idx * small_bytes);
    end else begin
      start = FseAddrWidth'(4 * small_bytes + medium_bytes + (idx - 5) * large_bytes);
    end
    return start;
  endfunction

endpackage

/* rtl/fse_sector_map.sv */
// ----------------------------------------------------------------------------
// fse_sector_map
// Checks an erase range against the flash size and finds the first sector
// and the number of sectors up to the rounded end.
// ----------------------------------------------------------------------------
module fse_sector_map import fse_pkg::*; #(
  parameter int unsigned SMALL_SECTOR_BYTES  = FseSmallSectorBytes,
  parameter int unsigned MEDIUM_SECTOR_BYTES = FseMediumSectorBytes,
  parameter int unsigned LARGE_SECTOR_BYTES  = FseLargeSectorBytes,
  parameter int unsigned SECTOR_COUNT        = FseSectorCount
) (
  input  logic [FseOffsetWidth-1:0] offset_i,
  input  logic [FseOffsetWidth-1:0] length_i,
  output sector_map_t               map_o
);

  localparam logic [FseAddrWidth-1:0] FlashSize =
    sector_start(SECTOR_COUNT, SMALL_SECTOR_BYTES, MEDIUM_SECTOR_BYTES, LARGE_SECTOR_BYTES);

  logic [FseAddrWidth-1:0] off_ext;
  logic [FseAddrWidth-1:0] end_ext;
  logic [FseLeftWidth-1:0] first_acc;
  logic [FseLeftWidth-1:0] total_acc;

  assign off_ext = FseAddrWidth'(offset_i);
  assign end_ext = FseAddrWidth'(offset_i) + FseAddrWidth'(length_i);

  // Starts are monotone: the first sector is the number of sector starts
  // (past the zeroth) at or below the offset, and every sector before it
  // also starts below the end, so the job count is the total less first.
  always_comb begin
    first_acc = '0;
    total_acc = '0;
    for (int unsigned i = 0; i < SECTOR_COUNT; i++) begin
      if (i > 0 && off_ext >= sector_start(i, SMALL_SECTOR_BYTES, MEDIUM_SECTOR_BYTES,
                                           LARGE_SECTOR_BYTES)) begin
        first_acc = first_acc + FseLeftWidth'(1);
      end
      if (end_ext > sector_start(i, SMALL_SECTOR_BYTES, MEDIUM_SECTOR_BYTES,
                                 LARGE_SECTOR_BYTES)) begin
        total_acc = total_acc + FseLeftWidth'(1);
      end
    end
  end

  assign map_o.addr_bad = (off_ext >= FlashSize);
  assign map_o.len_bad  = (length_i == '0) || (end_ext > FlashSize);
  assign map_o.first    = first_acc[FseSectorWidth-1:0];
  assign map_o.count    = total_acc - first_acc;

endmodule

/* rtl/flash_sector_erase_job_unit.sv */
// ----------------------------------------------------------------------------
// flash_sector_erase_job_unit
// Erase job controller: init, checked erase requests and one sector erase
// per tick while the flash is free.
// ----------------------------------------------------------------------------
// One item (init, erase request or tick) is taken per clock cycle, stalls
// apart, and gives one result item, which appears in the output register on
// the cycle after acceptance unless an earlier result is still waiting
// there, in which case it is held in the skid register until the output
// register frees up. The whole decision, including the parallel sector
// compares of the layout lookup, sits between the job state registers and
// the output register, so the rate is one item per cycle. A two-entry output
// stage (output register plus skid register) keeps in_ready_o high while one
// result waits; it drops only once both entries are occupied.
module flash_sector_erase_job_unit import fse_pkg::*; #(
  parameter int unsigned SMALL_SECTOR_BYTES  = FseSmallSectorBytes,
  parameter int unsigned MEDIUM_SECTOR_BYTES = FseMediumSectorBytes,
  parameter int unsigned LARGE_SECTOR_BYTES  = FseLargeSectorBytes,
  parameter int unsigned SECTOR_COUNT        = FseSectorCount
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  status_e                   status_q, status_d;
  logic                      pending_q, pending_d;
  logic [FseSectorWidth-1:0] next_q, next_d;
  logic [FseLeftWidth-1:0]   left_q, left_d;

  logic      out_valid_q;
  out_item_t out_q;
  logic      skid_valid_q;
  out_item_t skid_q;

  logic        accept;
  out_item_t   res;
  sector_map_t map;
  logic [FseLeftWidth-1:0] left_after;

  fse_sector_map #(
    .SMALL_SECTOR_BYTES (SMALL_SECTOR_BYTES),
    .MEDIUM_SECTOR_BYTES(MEDIUM_SECTOR_BYTES),
    .LARGE_SECTOR_BYTES (LARGE_SECTOR_BYTES),
    .SECTOR_COUNT       (SECTOR_COUNT)
  ) u_map (
    .offset_i(in_data_i.address_offset),
    .length_i(in_data_i.length_bytes),
    .map_o   (map)
  );

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    status_d       = status_q;
    pending_d      = pending_q;
    next_d         = next_q;
    left_d         = left_q;
    left_after     = left_q;
    res.error_code = ERR_NONE;
    res.erase_issue  = 1'b0;
    res.erase_sector = '0;
    unique case (in_data_i.command)
      CMD_INIT: begin
        // init goes ahead even over a running job, which is dropped
        if (status_q == ST_BUSY) res.error_code = ERR_BUSY;
        status_d  = ST_IDLE;
        pending_d = 1'b0;
        next_d    = '0;
        left_d    = '0;
      end
      CMD_ERASE: begin
        priority if (status_q == ST_UNINIT) begin
          res.error_code = ERR_UNINIT;
        end else if (status_q == ST_BUSY) begin
          res.error_code = ERR_BUSY;
        end else if (map.addr_bad) begin
          res.error_code = ERR_ADDR;
        end else if (map.len_bad) begin
          res.error_code = ERR_LEN;
        end else begin
          next_d    = map.first;
          left_d    = map.count;
          status_d  = ST_BUSY;
          pending_d = 1'b1;
        end
      end
      CMD_TICK: begin
        if (status_q == ST_UNINIT) begin
          res.error_code = ERR_UNINIT;
        end else if (pending_q) begin
          if (left_q != '0 && !in_data_i.flash_busy) begin
            res.erase_issue  = 1'b1;
            res.erase_sector = next_q;
            next_d     = next_q + FseSectorWidth'(1);
            left_after = left_q - FseLeftWidth'(1);
          end
          left_d = left_after;
          if (left_after == '0) begin
            pending_d = 1'b0;
            status_d  = ST_IDLE;
          end
        end
      end
      default: begin
        // unused command code: no effect
      end
    endcase
    res.status_now = status_d;
    res.job_result = pending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= ST_UNINIT;
      pending_q <= 1'b0;
      next_q    <= '0;
      left_q    <= '0;
    end else if (accept) begin
      status_q  <= status_d;
      pending_q <= pending_d;
      next_q    <= next_d;
      left_q    <= left_d;
    end
  end

  // output register with a skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/fse_checker.sv */
// ----------------------------------------------------------------------------
// fse_checker
// Port-level checks on the sector erase job unit, bound to the top level.
// ----------------------------------------------------------------------------
module fse_checker import fse_pkg::*; #(
  parameter int unsigned SECTOR_COUNT = FseSectorCount
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item changed while stalled");

  // a job is pending exactly while the unit reports busy
  a_pending_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.job_result == (out_data_o.status_now == ST_BUSY)))
    else $error("job result and status disagree");

  // an erase is only issued without error and within the layout
  a_issue_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.erase_issue |->
      out_data_o.error_code == ERR_NONE &&
      32'(out_data_o.erase_sector) < SECTOR_COUNT)
    else $error("bad sector erase issued");

  // no sector number without an issued erase
  a_sector_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.erase_issue |-> out_data_o.erase_sector == '0)
    else $error("sector reported without erase");

  // an uninitialised error leaves the unit uninitialised
  a_uninit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error_code == ERR_UNINIT |->
      out_data_o.status_now == ST_UNINIT)
    else $error("uninitialised error with status set");

endmodule

bind flash_sector_erase_job_unit fse_checker #(
  .SECTOR_COUNT(SECTOR_COUNT)
) u_fse_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

/* verif/tb_flash_sector_erase_job_unit.sv */
// ----------------------------------------------------------------------------
// tb_flash_sector_erase_job_unit
// Self-checking bench for the sector erase job unit. A short table of
// directed items is followed by random erase jobs, noise and bad requests.
// Every accepted item is run through a local job predictor, and each result
// item is checked field by field against the oldest queued expectation.
// ----------------------------------------------------------------------------
module tb_flash_sector_erase_job_unit;
  import fse_pkg::*;

  localparam int unsigned FlashBytes = 4 * FseSmallSectorBytes + FseMediumSectorBytes
                                     + (FseSectorCount - 5) * FseLargeSectorBytes;
  localparam int unsigned OffsetMax  = (1 << FseOffsetWidth) - 1;
  localparam logic [1:0]  CmdUnused  = 2'd3;
  localparam int          RandItems  = 420;
  localparam int          HoldCycles = 80;
  localparam int          TailCycles = 4;
  localparam int          StallLimit = 2000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } erase_row_t;

  logic      clk = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_data_o;

  // Predictor state
  status_e                   job_status = ST_UNINIT;
  bit                        job_open = 1'b0;
  logic [FseSectorWidth-1:0] next_sect = '0;
  logic [FseLeftWidth-1:0]   sect_left = '0;

  out_item_t  expected_q[$];
  erase_row_t dir_rows[$];
  int         fail_cnt = 0;
  int         stall_cnt = 0;
  bit         calm = 1'b0;
  bit         hold_req = 1'b0;

  flash_sector_erase_job_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned sector_base(input int unsigned idx);
    int unsigned base;
    if (idx <= 4) begin
      base = idx * FseSmallSectorBytes;
    end else begin
      base = 4 * FseSmallSectorBytes + FseMediumSectorBytes
           + (idx - 5) * FseLargeSectorBytes;
    end
    return base;
  endfunction

  function automatic out_item_t predict_erase_job(input in_item_t it);
    out_item_t   res;
    int unsigned off;
    int unsigned len;
    int unsigned stop;
    int unsigned first;
    int unsigned cnt;
    res  = '0;
    off  = 32'(it.address_offset);
    len  = 32'(it.length_bytes);
    case (it.command)
      CMD_INIT: begin
        if (job_status == ST_BUSY) res.error_code = ERR_BUSY;
        job_status = ST_IDLE;
        job_open   = 1'b0;
        next_sect  = '0;
        sect_left  = '0;
      end
      CMD_ERASE: begin
        if (job_status == ST_UNINIT) begin
          res.error_code = ERR_UNINIT;
        end else if (job_status == ST_BUSY) begin
          res.error_code = ERR_BUSY;
        end else if (off >= FlashBytes) begin
          res.error_code = ERR_ADDR;
        end else if (len == 0 || off + len > FlashBytes) begin
          res.error_code = ERR_LEN;
        end else begin
          stop  = off + len;
          first = FseSectorCount - 1;
          cnt   = 0;
          // walk down so the lowest matching sector wins
          for (int i = FseSectorCount - 2; i >= 0; i--) begin
            if (off < sector_base(i + 1)) first = i;
          end
          for (int i = 0; i < FseSectorCount; i++) begin
            if (i >= first && stop > sector_base(i)) cnt++;
          end
          next_sect  = FseSectorWidth'(first);
          sect_left  = FseLeftWidth'(cnt);
          job_status = ST_BUSY;
          job_open   = 1'b1;
        end
      end
      CMD_TICK: begin
        if (job_status == ST_UNINIT) begin
          res.error_code = ERR_UNINIT;
        end else if (job_open) begin
          if (sect_left != 0 && !it.flash_busy) begin
            res.erase_issue  = 1'b1;
            res.erase_sector = next_sect;
            next_sect        = next_sect + 1'b1;
            sect_left        = sect_left - 1'b1;
          end
          if (sect_left == 0) begin
            job_open   = 1'b0;
            job_status = ST_IDLE;
          end
        end
      end
      default: ;
    endcase
    res.status_now = job_status;
    res.job_result = job_open;
    return res;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input int unsigned off,
                         input int unsigned len, input int fb, input int typed,
                         input err_e err, input status_e st, input int job,
                         input int iss, input int unsigned sect);
    erase_row_t r;
    r.item.command        = cmd;
    r.item.address_offset = FseOffsetWidth'(off);
    r.item.length_bytes   = FseOffsetWidth'(len);
    r.item.flash_busy     = 1'(fb);
    r.typed               = 1'(typed);
    r.res                 = {err, st, 1'(job), 1'(iss), FseSectorWidth'(sect)};
    dir_rows.push_back(r);
  endtask

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t pred;
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    pred = predict_erase_job(it);
    expected_q.push_back(typed ? typed_res : pred);
  endtask

  function automatic in_item_t noise_item(input logic [1:0] cmd);
    in_item_t it;
    it.command        = cmd;
    it.address_offset = FseOffsetWidth'($urandom_range(OffsetMax, 0));
    it.length_bytes   = FseOffsetWidth'($urandom_range(OffsetMax, 0));
    it.flash_busy     = 1'($urandom_range(1, 0));
    return it;
  endfunction

  // Receiver: random stalls, a calm stretch and one long hold-off
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 19);
      end
    end
  end

  // Result check against the oldest queued expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result item %h at %0t", out_data_o, $time);
      end else begin
        want = expected_q.pop_front();
        if (want.error_code !== out_data_o.error_code ||
            want.status_now !== out_data_o.status_now ||
            want.job_result !== out_data_o.job_result ||
            want.erase_issue !== out_data_o.erase_issue ||
            want.erase_sector !== out_data_o.erase_sector) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("mismatch at %0t: err %0d/%0d st %0d/%0d job %0d/%0d",
                     $time, want.error_code, out_data_o.error_code,
                     want.status_now, out_data_o.status_now,
                     want.job_result, out_data_o.job_result);
            $display("  iss %0d/%0d sect %0d/%0d",
                     want.erase_issue, out_data_o.erase_issue,
                     want.erase_sector, out_data_o.erase_sector);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    in_item_t    it;
    out_item_t   none;
    int unsigned off;
    int unsigned len;
    int unsigned room;
    int unsigned n;
    int unsigned k;
    int          rnd_count;
    bit          hold_done;
    bit          pause_done;

    none       = '0;
    rnd_count  = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    // before init, bad requests, one-sector job at the top, whole-flash job,
    // init while busy, boundary-crossing jobs
    add_row(CMD_TICK,  0, 0, 0, 1, ERR_UNINIT, ST_UNINIT, 0, 0, 0);
    add_row(CMD_ERASE, 0, 1, 0, 1, ERR_UNINIT, ST_UNINIT, 0, 0, 0);
    add_row(CmdUnused, OffsetMax, OffsetMax, 1, 1, ERR_NONE, ST_UNINIT, 0, 0, 0);
    add_row(CMD_INIT,  0, 0, 0, 1, ERR_NONE, ST_IDLE, 0, 0, 0);
    add_row(CMD_ERASE, FlashBytes, 1, 0, 1, ERR_ADDR, ST_IDLE, 0, 0, 0);
    add_row(CMD_ERASE, OffsetMax, OffsetMax, 1, 1, ERR_ADDR, ST_IDLE, 0, 0, 0);
    add_row(CMD_ERASE, 0, 0, 0, 1, ERR_LEN, ST_IDLE, 0, 0, 0);
    add_row(CMD_ERASE, 0, OffsetMax, 0, 1, ERR_LEN, ST_IDLE, 0, 0, 0);
    add_row(CMD_ERASE, FlashBytes - 1, 2, 0, 1, ERR_LEN, ST_IDLE, 0, 0, 0);
    add_row(CMD_TICK,  0, 0, 0, 1, ERR_NONE, ST_IDLE, 0, 0, 0);
    add_row(CMD_ERASE, FlashBytes - 1, 1, 0, 1, ERR_NONE, ST_BUSY, 1, 0, 0);
    add_row(CMD_TICK,  0, 0, 1, 1, ERR_NONE, ST_BUSY, 1, 0, 0);
    add_row(CMD_TICK,  0, 0, 0, 1, ERR_NONE, ST_IDLE, 0, 1, FseSectorCount - 1);
    add_row(CMD_ERASE, 0, FlashBytes, 0, 1, ERR_NONE, ST_BUSY, 1, 0, 0);
    add_row(CMD_ERASE, 0, 1, 0, 1, ERR_BUSY, ST_BUSY, 1, 0, 0);
    add_row(CMD_TICK,  0, 0, 0, 1, ERR_NONE, ST_BUSY, 1, 1, 0);
    add_row(CMD_TICK,  0, 0, 0, 0, ERR_NONE, ST_UNINIT, 0, 0, 0);
    add_row(CMD_INIT,  0, 0, 0, 1, ERR_BUSY, ST_IDLE, 0, 0, 0);
    add_row(CMD_ERASE, FseSmallSectorBytes - 1, 2, 0, 0, ERR_NONE, ST_UNINIT, 0, 0, 0);
    add_row(CMD_TICK,  0, 0, 0, 0, ERR_NONE, ST_UNINIT, 0, 0, 0);
    add_row(CMD_TICK,  0, 0, 0, 0, ERR_NONE, ST_UNINIT, 0, 0, 0);
    add_row(CMD_ERASE, 4 * FseSmallSectorBytes, FseMediumSectorBytes + 1, 0, 0,
            ERR_NONE, ST_UNINIT, 0, 0, 0);
    add_row(CMD_TICK,  0, 0, 0, 0, ERR_NONE, ST_UNINIT, 0, 0, 0);
    add_row(CMD_TICK,  0, 0, 0, 0, ERR_NONE, ST_UNINIT, 0, 0, 0);
    add_row(CMD_TICK,  0, 0, 0, 0, ERR_NONE, ST_UNINIT, 0, 0, 0);

    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    while (rnd_count < RandItems) begin
      if (!hold_done && rnd_count >= 60) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      calm = (rnd_count >= 150 && rnd_count < 260);
      if (!pause_done && rnd_count >= 340) begin
        pause_done = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
      end
      k = $urandom_range(99);
      if (k < 70) begin
        // well-formed job: valid request, then a run of ticks
        off  = $urandom_range(FlashBytes - 1, 0);
        room = FlashBytes - off;
        k    = $urandom_range(99);
        if (k < 45) len = $urandom_range(room < 32768 ? room : 32768, 1);
        else if (k < 85) len = $urandom_range(room, 1);
        else len = room;
        it                = noise_item(CMD_ERASE);
        it.address_offset = FseOffsetWidth'(off);
        it.length_bytes   = FseOffsetWidth'(len);
        send_item(it, 1'b0, none);
        rnd_count++;
        n = $urandom_range(20, 1);
        repeat (n) begin
          it            = noise_item(CMD_TICK);
          it.flash_busy = ($urandom_range(99) < 30);
          send_item(it, 1'b0, none);
          rnd_count++;
        end
      end else if (k < 80) begin
        send_item(noise_item(CMD_INIT), 1'b0, none);
        rnd_count++;
      end else if (k < 90) begin
        send_item(noise_item(CMD_ERASE), 1'b0, none);
        rnd_count++;
      end else begin
        it = noise_item(2'($urandom_range(3, 0)));
        send_item(it, 1'b0, none);
        if (it.command != CmdUnused) rnd_count++;
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
